/* design/spts_pkg.sv */
package spts_pkg;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_EVAL  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  localparam int unsigned ExpW   = 8;
  localparam int unsigned CoeffW = 32;
  localparam int unsigned EntryW = ExpW + CoeffW;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        term_exp;
    logic signed [31:0] term_coeff;
    logic signed [15:0] x_value;
    logic [5:0]        read_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] eval_result;
    logic [7:0]         out_exp;
    logic signed [31:0] out_coeff;
    logic [6:0]         count_now;
  } out_t;

endpackage

/* design/spts_ram.sv */
module spts_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/sparse_polynomial_term_store.sv */
// Sparse polynomial term store.
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one command per
// transaction: add a term, evaluate at an integer x, clear, or read a term by
// its position. Every command produces exactly one result transaction on the
// output channel (out_valid_o, out_ready_i, out_data_o).
// Terms live in one RAM of MAX_TERMS entries, sorted by falling exponent.
// Clear and zero-coefficient adds go straight to the result; a read first
// fetches the addressed term. An add scans the table one entry at a time and
// then shifts the tail by one entry at a time to open a slot for the term.
// An evaluation visits each term through one shared 32x32 multiplier: each
// power step multiplies p by |x|, a last step multiplies it by the magnitude
// of the coefficient, and the term value is added into a saturating
// accumulator; the whole item visits every held term.
// The block takes one command at a time; in_ready_o is high only while it is
// idle. A finished result sits in an output register; while the receiver
// stalls, the next command may still be taken, and its result waits until
// the register is free.
// Reset empties the table (the term count goes to zero) and drops the
// output valid flag; no clearing pass over the RAM is needed.
module sparse_polynomial_term_store #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spts_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spts_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SCAN_RD = 4'd1;
  localparam logic [3:0] ST_SCAN_CM = 4'd2;
  localparam logic [3:0] ST_INS_RD  = 4'd3;
  localparam logic [3:0] ST_INS_WR  = 4'd4;
  localparam logic [3:0] ST_DEL_RD  = 4'd5;
  localparam logic [3:0] ST_DEL_WR  = 4'd6;
  localparam logic [3:0] ST_EV_RD   = 4'd7;
  localparam logic [3:0] ST_EV_LD   = 4'd8;
  localparam logic [3:0] ST_EV_CHK  = 4'd9;
  localparam logic [3:0] ST_EV_M0   = 4'd10;
  localparam logic [3:0] ST_EV_M1   = 4'd11;
  localparam logic [3:0] ST_EV_M2   = 4'd12;
  localparam logic [3:0] ST_EV_ACC  = 4'd13;
  localparam logic [3:0] ST_RD_OUT  = 4'd14;
  localparam logic [3:0] ST_PUSH    = 4'd15;

  localparam logic [63:0] TWO63   = {1'b1, 63'd0};
  localparam logic [63:0] I64_MAX = {1'b0, {63{1'b1}}};

  logic [3:0] state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] k_q;

  // Captured command.
  logic [7:0]  e_in_q;
  logic [31:0] c_in_q;
  logic [15:0] ax_q;
  logic        xneg_q;

  // Evaluation datapath.
  logic [7:0]  i_q;
  logic [31:0] ac_q;
  logic        neg_q;
  logic        fin_q;
  logic        huge_q;
  logic [63:0] p_q;
  logic [63:0] mul_q;
  logic [63:0] lo_q;
  logic [63:0] acc_q;
  logic        ovf_q;

  // Result being built and output register.
  logic [1:0]  res_status_q;
  logic [63:0] res_eval_q;
  logic [7:0]  res_exp_q;
  logic [31:0] res_coeff_q;
  logic        out_valid_q;
  spts_pkg::out_t out_q;

  // RAM port.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [spts_pkg::EntryW-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [spts_pkg::EntryW-1:0] ram_rdata;
  logic [7:0]                  rd_exp;
  logic [31:0]                 rd_coeff;

  spts_ram #(
    .WIDTH(spts_pkg::EntryW),
    .DEPTH(MAX_TERMS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_exp   = ram_rdata[spts_pkg::EntryW-1:spts_pkg::CoeffW];
  assign rd_coeff = ram_rdata[spts_pkg::CoeffW-1:0];

  // Command decode helpers.
  logic          in_fire;
  logic          idx_ok;
  logic [31:0]   idx_ext;
  logic [31:0]   cnt_ext;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;
  logic          full;

  assign in_fire = in_valid_i && in_ready_o;
  assign idx_ext = 32'(in_data_i.read_index);
  assign cnt_ext = 32'(cnt_q);
  assign idx_ok  = (idx_ext < cnt_ext) && (idx_ext < MAX_TERMS);
  assign pos_inc = pos_q + CW'(1);
  assign k_inc   = k_q + CW'(1);
  assign k_dec   = k_q - CW'(1);
  assign full    = (cnt_ext >= MAX_TERMS);

  // Merge of an incoming coefficient into a held one, saturated to 32 bits.
  logic signed [32:0] sum33;
  logic [31:0]        merged;
  logic               merge_ovf;

  always_comb begin
    sum33     = 33'(signed'(rd_coeff)) + 33'(signed'(c_in_q));
    merged    = sum33[31:0];
    merge_ovf = 1'b0;
    if (sum33[32] != sum33[31]) begin
      merge_ovf = 1'b1;
      merged    = sum33[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
  end

  // Shared multiplier: one 32x32 product per cycle over the two halves of p.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [95:0] full_prod;
  logic        prod_huge;

  always_comb begin
    mul_a     = (state_q == ST_EV_M1) ? p_q[63:32] : p_q[31:0];
    mul_b     = fin_q ? ac_q : 32'(ax_q);
    mul_p     = mul_a * mul_b;
    full_prod = {mul_q, 32'd0} + 96'(lo_q);
    prod_huge = (full_prod[95:64] != 32'd0) ||
                (full_prod[63] && (full_prod[62:0] != 63'd0));
  end

  // Term value and saturating accumulation.
  logic [63:0] term_v;
  logic        term_ovf;
  logic [63:0] acc_sum;
  logic [63:0] acc_next;
  logic        acc_ovf;

  always_comb begin
    term_ovf = 1'b0;
    if (huge_q) begin
      term_ovf = 1'b1;
      term_v   = neg_q ? TWO63 : I64_MAX;
    end else if (neg_q) begin
      term_v = (p_q == TWO63) ? TWO63 : (64'd0 - p_q);
    end else if (p_q == TWO63) begin
      term_ovf = 1'b1;
      term_v   = I64_MAX;
    end else begin
      term_v = p_q;
    end
    acc_sum  = acc_q + term_v;
    acc_next = acc_sum;
    acc_ovf  = 1'b0;
    if ((acc_q[63] == term_v[63]) && (acc_sum[63] != acc_q[63])) begin
      acc_ovf  = 1'b1;
      acc_next = acc_q[63] ? TWO63 : I64_MAX;
    end
  end

  // Sequencer next state and RAM control.
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q[AW-1:0];
    ram_wdata = {e_in_q, c_in_q};
    ram_raddr = pos_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        ram_raddr = AW'(idx_ext);
        if (in_fire) begin
          case (in_data_i.kind)
            spts_pkg::KIND_ADD: begin
              state_d = (in_data_i.term_coeff == 32'sd0) ? ST_PUSH : ST_SCAN_RD;
            end
            spts_pkg::KIND_EVAL:  state_d = ST_EV_RD;
            spts_pkg::KIND_CLEAR: state_d = ST_PUSH;
            default:              state_d = idx_ok ? ST_RD_OUT : ST_PUSH;
          endcase
        end
      end
      ST_SCAN_RD: begin
        if (pos_q >= cnt_q) begin
          state_d = full ? ST_PUSH : ST_INS_RD;
        end else begin
          state_d = ST_SCAN_CM;
        end
      end
      ST_SCAN_CM: begin
        if (rd_exp > e_in_q) begin
          state_d = ST_SCAN_RD;
        end else if (rd_exp == e_in_q) begin
          if (merged == 32'd0) begin
            state_d = ST_DEL_RD;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = {rd_exp, merged};
            state_d   = ST_PUSH;
          end
        end else begin
          state_d = full ? ST_PUSH : ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        ram_raddr = k_dec[AW-1:0];
        if (k_q == pos_q) begin
          ram_we  = 1'b1;
          state_d = ST_PUSH;
        end else begin
          state_d = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = ST_INS_RD;
      end
      ST_DEL_RD: begin
        ram_raddr = k_inc[AW-1:0];
        state_d   = (k_inc >= cnt_q) ? ST_PUSH : ST_DEL_WR;
      end
      ST_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = ST_DEL_RD;
      end
      ST_EV_RD: begin
        ram_raddr = k_q[AW-1:0];
        state_d   = (k_q >= cnt_q) ? ST_PUSH : ST_EV_LD;
      end
      ST_EV_LD:  state_d = ST_EV_CHK;
      ST_EV_CHK: state_d = ST_EV_M0;
      ST_EV_M0:  state_d = ST_EV_M1;
      ST_EV_M1:  state_d = ST_EV_M2;
      ST_EV_M2:  state_d = (prod_huge || fin_q) ? ST_EV_ACC : ST_EV_CHK;
      ST_EV_ACC: state_d = ST_EV_RD;
      ST_RD_OUT: state_d = ST_PUSH;
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PUSH && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire && in_data_i.kind == spts_pkg::KIND_CLEAR) begin
        cnt_q <= '0;
      end else if (state_q == ST_INS_RD && k_q == pos_q) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (state_q == ST_DEL_RD && k_inc >= cnt_q) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        e_in_q       <= in_data_i.term_exp;
        c_in_q       <= in_data_i.term_coeff;
        xneg_q       <= in_data_i.x_value[15];
        ax_q         <= in_data_i.x_value[15] ? (16'd0 - in_data_i.x_value)
                                               : in_data_i.x_value;
        pos_q        <= '0;
        k_q          <= '0;
        acc_q        <= '0;
        ovf_q        <= 1'b0;
        res_status_q <= (in_data_i.kind == spts_pkg::KIND_READ && !idx_ok)
                        ? spts_pkg::STATUS_RANGE : spts_pkg::STATUS_OK;
        res_eval_q   <= '0;
        res_exp_q    <= '0;
        res_coeff_q  <= '0;
      end
      ST_SCAN_RD: begin
        k_q <= cnt_q;
        if (pos_q >= cnt_q && full) begin
          res_status_q <= spts_pkg::STATUS_FULL;
        end
      end
      ST_SCAN_CM: begin
        k_q <= cnt_q;
        if (rd_exp > e_in_q) begin
          pos_q <= pos_inc;
        end else if (rd_exp == e_in_q) begin
          k_q <= pos_q;
          if (merge_ovf) begin
            res_status_q <= spts_pkg::STATUS_OVF;
          end
        end else if (full) begin
          res_status_q <= spts_pkg::STATUS_FULL;
        end
      end
      ST_INS_WR: k_q <= k_dec;
      ST_DEL_WR: k_q <= k_inc;
      ST_EV_RD: begin
        res_eval_q   <= acc_q;
        res_status_q <= ovf_q ? spts_pkg::STATUS_OVF : spts_pkg::STATUS_OK;
      end
      ST_EV_LD: begin
        i_q    <= rd_exp;
        ac_q   <= rd_coeff[31] ? (32'd0 - rd_coeff) : rd_coeff;
        neg_q  <= rd_coeff[31] ^ (xneg_q & rd_exp[0]);
        p_q    <= 64'd1;
        fin_q  <= 1'b0;
        huge_q <= 1'b0;
      end
      ST_EV_CHK: begin
        // Power steps stop once p is zero; x of magnitude one leaves p at one.
        if (!(i_q != 8'd0 && p_q != 64'd0 && ax_q != 16'd1)) begin
          fin_q <= 1'b1;
        end
      end
      ST_EV_M0: mul_q <= mul_p;
      ST_EV_M1: begin
        lo_q  <= mul_q;
        mul_q <= mul_p;
      end
      ST_EV_M2: begin
        if (prod_huge) begin
          huge_q <= 1'b1;
        end else begin
          p_q <= full_prod[63:0];
          i_q <= i_q - 8'd1;
        end
      end
      ST_EV_ACC: begin
        acc_q <= acc_next;
        ovf_q <= ovf_q | term_ovf | acc_ovf;
        k_q   <= k_inc;
      end
      ST_RD_OUT: begin
        res_exp_q   <= rd_exp;
        res_coeff_q <= rd_coeff;
      end
      default: ;
    endcase
    if (state_q == ST_PUSH && (!out_valid_q || out_ready_i)) begin
      out_q.status      <= res_status_q;
      out_q.eval_result <= res_eval_q;
      out_q.out_exp     <= res_exp_q;
      out_q.out_coeff   <= res_coeff_q;
      out_q.count_now   <= 7'(32'(cnt_q));
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
